// File: rtl/core/glzw_pkg.sv
// Shared types and constants for the GIF LZW code decoder.
package glzw_pkg;

  localparam int unsigned MAX_CODE_BITS_DEF = 12;
  localparam int unsigned DICT_ENTRIES_DEF  = 4096;

  localparam int unsigned CODE_W  = 12;
  localparam int unsigned CMP_W   = CODE_W + 1;
  localparam int unsigned LEN_W   = 12;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WIDTH_W = 4;
  localparam int unsigned SIZE_W  = 4;

  localparam logic [LEN_W-1:0]  LEN_MAX        = '1;
  localparam logic [SIZE_W-1:0] MIN_SIZE_LO    = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] MIN_SIZE_HI    = SIZE_W'(8);
  localparam logic [SIZE_W-1:0] RESET_MIN_SIZE = SIZE_W'(8);

  typedef enum logic [2:0] {
    ST_EMIT     = 3'd0,
    ST_CLEAR    = 3'd1,
    ST_END      = 3'd2,
    ST_NO_CLEAR = 3'd3,
    ST_BAD      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_WAIT_CLEAR = 2'd0,
    PH_FIRST      = 2'd1,
    PH_DECODE     = 2'd2,
    PH_ENDED      = 2'd3
  } phase_e;

  // Classification of one code against the current decoder state.
  typedef enum logic [2:0] {
    K_ENDED,
    K_NO_CLEAR,
    K_CLEAR,
    K_EOI,
    K_FIRST_ROOT,
    K_KNOWN,
    K_NEW,
    K_BAD
  } kind_e;

  // One dictionary entry as held in the RAM.
  typedef struct packed {
    logic [BYTE_W-1:0] suffix;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] head;
  } entry_t;

endpackage

// File: rtl/core/glzw_dict_ram.sv
// Dictionary RAM: one write port, one registered read port with write forwarding.
module glzw_dict_ram #(
  parameter int unsigned DictEntries = glzw_pkg::DICT_ENTRIES_DEF,
  localparam int unsigned AddrW = $clog2(DictEntries)
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output glzw_pkg::entry_t    rd_data_o,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  glzw_pkg::entry_t    wr_data_i
);

  glzw_pkg::entry_t mem [DictEntries];
  glzw_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    // A read of the entry being written in the same cycle takes the new word.
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

// File: rtl/core/glzw_step.sv
// Decode stage: classifies each code, updates the dictionary state and holds the result.
module glzw_step #(
  parameter int unsigned MaxCodeBits = glzw_pkg::MAX_CODE_BITS_DEF,
  parameter int unsigned DictEntries = glzw_pkg::DICT_ENTRIES_DEF,
  localparam int unsigned AddrW = $clog2(DictEntries),
  localparam int unsigned NfW   = AddrW + 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // code input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [glzw_pkg::CODE_W-1:0]       code_i,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [glzw_pkg::SIZE_W-1:0]       min_code_size_i,
  // dictionary RAM
  output logic                              rd_en_o,
  output logic [AddrW-1:0]                  rd_addr_o,
  input  glzw_pkg::entry_t                  rd_data_i,
  output logic                              wr_en_o,
  output logic [AddrW-1:0]                  wr_addr_o,
  output glzw_pkg::entry_t                  wr_data_o,
  // result
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        status_o,
  output logic [glzw_pkg::CODE_W-1:0]       string_code_o,
  output logic [glzw_pkg::LEN_W-1:0]        string_length_o,
  output logic [glzw_pkg::BYTE_W-1:0]       first_byte_o,
  output logic [glzw_pkg::BYTE_W-1:0]       last_byte_o,
  output logic                              entry_added_o,
  output logic [glzw_pkg::CODE_W-1:0]       added_index_o,
  output logic [glzw_pkg::WIDTH_W-1:0]      next_width_o
);

  localparam int unsigned CodeW  = glzw_pkg::CODE_W;
  localparam int unsigned CmpW   = glzw_pkg::CMP_W;
  localparam int unsigned LenW   = glzw_pkg::LEN_W;
  localparam int unsigned ByteW  = glzw_pkg::BYTE_W;
  localparam int unsigned WidthW = glzw_pkg::WIDTH_W;
  localparam int unsigned SizeW  = glzw_pkg::SIZE_W;

  localparam logic [NfW-1:0] NfFull = NfW'(DictEntries);
  localparam logic [NfW-1:0] NfReset =
      NfW'((CodeW'(1) << glzw_pkg::RESET_MIN_SIZE) + CodeW'(2));
  localparam logic [WidthW-1:0] WidthReset = WidthW'(glzw_pkg::RESET_MIN_SIZE) + WidthW'(1);
  localparam logic [WidthW-1:0] WidthMax   = WidthW'(MaxCodeBits);

  // Stage holding the code whose dictionary word is on rd_data_i.
  logic                b_valid_q;
  logic [CodeW-1:0]    b_code_q;

  glzw_pkg::phase_e    phase_q, phase_d;
  logic [NfW-1:0]      next_free_q, next_free_d;
  logic [WidthW-1:0]   code_width_q, code_width_d;
  logic [SizeW-1:0]    size_q;
  logic [LenW-1:0]     prev_len_q, prev_len_d;
  logic [ByteW-1:0]    prev_first_q, prev_first_d;

  logic                out_valid_q;
  glzw_pkg::status_e   status_q, status_d;
  logic [CodeW-1:0]    s_code_q, s_code_d;
  logic [LenW-1:0]     s_len_q, s_len_d;
  logic [ByteW-1:0]    s_first_q, s_first_d;
  logic [ByteW-1:0]    s_last_q, s_last_d;
  logic                added_q, added_d;
  logic [CodeW-1:0]    added_idx_q, added_idx_d;
  logic [WidthW-1:0]   width_out_q;

  logic                accept;
  logic                b_fire;
  logic [SizeW-1:0]    cfg_size;
  logic [CodeW-1:0]    clr;
  logic [CodeW-1:0]    eoi;
  logic [CmpW-1:0]     code_cmp;
  logic [CmpW-1:0]     nf_cmp;
  logic                dict_full;
  logic                is_root;
  logic [LenW-1:0]     look_len;
  logic [ByteW-1:0]    look_first;
  logic [ByteW-1:0]    look_last;
  logic [LenW-1:0]     new_len;
  logic                grow;
  glzw_pkg::kind_e     kind;

  assign b_fire      = b_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = b_valid_q && !b_fire;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !b_valid_q;

  assign rd_en_o   = accept;
  assign rd_addr_o = code_i[AddrW-1:0];

  always_comb begin
    if (min_code_size_i < glzw_pkg::MIN_SIZE_LO) begin
      cfg_size = glzw_pkg::MIN_SIZE_LO;
    end else if (min_code_size_i > glzw_pkg::MIN_SIZE_HI) begin
      cfg_size = glzw_pkg::MIN_SIZE_HI;
    end else begin
      cfg_size = min_code_size_i;
    end
  end

  assign clr       = CodeW'(1) << size_q;
  assign eoi       = clr + CodeW'(1);
  assign code_cmp  = CmpW'(b_code_q);
  assign nf_cmp    = CmpW'(next_free_q);
  assign dict_full = (next_free_q == NfFull);

  // Root codes are implicit one-byte strings; others come from the RAM.
  assign is_root    = (b_code_q < clr);
  assign look_len   = is_root ? LenW'(1) : rd_data_i.length;
  assign look_first = is_root ? b_code_q[ByteW-1:0] : rd_data_i.head;
  assign look_last  = is_root ? b_code_q[ByteW-1:0] : rd_data_i.suffix;

  // The previous string's length and first byte are kept from its own result.
  assign new_len = (prev_len_q == glzw_pkg::LEN_MAX) ? glzw_pkg::LEN_MAX
                                                     : prev_len_q + LenW'(1);
  assign grow = (nf_cmp == ((CmpW'(1) << code_width_q) - CmpW'(1))) &&
                (code_width_q < WidthMax);

  always_comb begin
    if (phase_q == glzw_pkg::PH_ENDED) begin
      kind = glzw_pkg::K_ENDED;
    end else if (phase_q == glzw_pkg::PH_WAIT_CLEAR && b_code_q != clr) begin
      kind = glzw_pkg::K_NO_CLEAR;
    end else if (b_code_q == clr) begin
      kind = glzw_pkg::K_CLEAR;
    end else if (b_code_q == eoi) begin
      kind = glzw_pkg::K_EOI;
    end else if (phase_q == glzw_pkg::PH_FIRST) begin
      kind = is_root ? glzw_pkg::K_FIRST_ROOT : glzw_pkg::K_BAD;
    end else if (code_cmp < nf_cmp) begin
      kind = glzw_pkg::K_KNOWN;
    end else if (code_cmp == nf_cmp && !dict_full) begin
      kind = glzw_pkg::K_NEW;
    end else begin
      kind = glzw_pkg::K_BAD;
    end
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (kind)
      glzw_pkg::K_CLEAR:      phase_d = glzw_pkg::PH_FIRST;
      glzw_pkg::K_EOI:        phase_d = glzw_pkg::PH_ENDED;
      glzw_pkg::K_FIRST_ROOT: phase_d = glzw_pkg::PH_DECODE;
      default:                phase_d = phase_q;
    endcase
  end

  // Result and dictionary update.
  always_comb begin
    status_d     = glzw_pkg::ST_BAD;
    s_code_d     = '0;
    s_len_d      = '0;
    s_first_d    = '0;
    s_last_d     = '0;
    added_d      = 1'b0;
    added_idx_d  = '0;
    next_free_d  = next_free_q;
    code_width_d = code_width_q;
    prev_len_d   = prev_len_q;
    prev_first_d = prev_first_q;
    wr_en_o      = 1'b0;
    wr_addr_o    = next_free_q[AddrW-1:0];
    wr_data_o.suffix = look_first;
    wr_data_o.length = new_len;
    wr_data_o.head   = prev_first_q;
    case (kind)
      glzw_pkg::K_ENDED: begin
        status_d = glzw_pkg::ST_END;
      end
      glzw_pkg::K_NO_CLEAR: begin
        status_d = glzw_pkg::ST_NO_CLEAR;
      end
      glzw_pkg::K_CLEAR: begin
        status_d     = glzw_pkg::ST_CLEAR;
        next_free_d  = NfW'(clr + CodeW'(2));
        code_width_d = WidthW'(size_q) + WidthW'(1);
      end
      glzw_pkg::K_EOI: begin
        status_d = glzw_pkg::ST_END;
      end
      glzw_pkg::K_FIRST_ROOT: begin
        status_d     = glzw_pkg::ST_EMIT;
        s_code_d     = b_code_q;
        s_len_d      = LenW'(1);
        s_first_d    = b_code_q[ByteW-1:0];
        s_last_d     = b_code_q[ByteW-1:0];
        prev_len_d   = LenW'(1);
        prev_first_d = b_code_q[ByteW-1:0];
      end
      glzw_pkg::K_KNOWN: begin
        status_d     = glzw_pkg::ST_EMIT;
        s_code_d     = b_code_q;
        s_len_d      = look_len;
        s_first_d    = look_first;
        s_last_d     = look_last;
        prev_len_d   = look_len;
        prev_first_d = look_first;
        if (!dict_full) begin
          wr_en_o     = 1'b1;
          added_d     = 1'b1;
          added_idx_d = CodeW'(next_free_q);
          next_free_d = next_free_q + NfW'(1);
          if (grow) begin
            code_width_d = code_width_q + WidthW'(1);
          end
        end
      end
      glzw_pkg::K_NEW: begin
        // Code not yet in the table: the string is previous plus its own first byte.
        status_d         = glzw_pkg::ST_EMIT;
        s_code_d         = b_code_q;
        s_len_d          = new_len;
        s_first_d        = prev_first_q;
        s_last_d         = prev_first_q;
        prev_len_d       = new_len;
        wr_en_o          = 1'b1;
        wr_data_o.suffix = prev_first_q;
        added_d          = 1'b1;
        added_idx_d      = CodeW'(next_free_q);
        next_free_d      = next_free_q + NfW'(1);
        if (grow) begin
          code_width_d = code_width_q + WidthW'(1);
        end
      end
      default: begin
        status_d = glzw_pkg::ST_BAD;
      end
    endcase
    if (!b_fire) begin
      wr_en_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= glzw_pkg::PH_WAIT_CLEAR;
      next_free_q  <= NfReset;
      code_width_q <= WidthReset;
      size_q       <= glzw_pkg::RESET_MIN_SIZE;
    end else begin
      if (accept) begin
        b_valid_q <= 1'b1;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      if (b_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        size_q       <= cfg_size;
        phase_q      <= glzw_pkg::PH_WAIT_CLEAR;
        next_free_q  <= NfW'((CodeW'(1) << cfg_size) + CodeW'(2));
        code_width_q <= WidthW'(cfg_size) + WidthW'(1);
      end else if (b_fire) begin
        phase_q      <= phase_d;
        next_free_q  <= next_free_d;
        code_width_q <= code_width_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_code_q <= code_i;
    end
    if (b_fire) begin
      prev_len_q   <= prev_len_d;
      prev_first_q <= prev_first_d;
      status_q     <= status_d;
      s_code_q     <= s_code_d;
      s_len_q      <= s_len_d;
      s_first_q    <= s_first_d;
      s_last_q     <= s_last_d;
      added_q      <= added_d;
      added_idx_q  <= added_idx_d;
      width_out_q  <= code_width_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign string_code_o   = s_code_q;
  assign string_length_o = s_len_q;
  assign first_byte_o    = s_first_q;
  assign last_byte_o     = s_last_q;
  assign entry_added_o   = added_q;
  assign added_index_o   = added_idx_q;
  assign next_width_o    = width_out_q;

endmodule

// File: rtl/core/gif_lzw_code_decoder.sv
// GIF LZW code decoder top level: decode stage plus dictionary RAM.
//
// Takes one unpacked LZW code per word and returns one result word per code. A
// new code may be accepted every clock cycle while in_stall_o is low. The edge that
// accepts a code also registers the dictionary RAM read of that code's entry. Once
// the result register is free, the decode stage decodes the code, writes the new
// entry and loads the result register, which drives the outputs. The entry
// written by one code is forwarded to the read of the next, so back-to-back codes
// never wait on the RAM. While a result is held by out_stall_i, the code behind it
// waits in the decode stage and in_stall_o is raised in the same cycle. The
// dictionary RAM holds suffix, length and first byte per entry and needs no
// clearing pass after reset or a clear code. A write of min_code_size restarts
// decoding and is taken only while the decode stage holds no code.
module gif_lzw_code_decoder #(
  parameter int unsigned MAX_CODE_BITS = glzw_pkg::MAX_CODE_BITS_DEF,
  parameter int unsigned DICT_ENTRIES  = glzw_pkg::DICT_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [glzw_pkg::CODE_W-1:0]   code_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [glzw_pkg::SIZE_W-1:0]   min_code_size_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [glzw_pkg::CODE_W-1:0]   string_code_o,
  output logic [glzw_pkg::LEN_W-1:0]    string_length_o,
  output logic [glzw_pkg::BYTE_W-1:0]   first_byte_o,
  output logic [glzw_pkg::BYTE_W-1:0]   last_byte_o,
  output logic                          entry_added_o,
  output logic [glzw_pkg::CODE_W-1:0]   added_index_o,
  output logic [glzw_pkg::WIDTH_W-1:0]  next_width_o
);

  localparam int unsigned AddrW = $clog2(DICT_ENTRIES);

  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  glzw_pkg::entry_t  rd_data;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  glzw_pkg::entry_t  wr_data;

  glzw_step #(
    .MaxCodeBits (MAX_CODE_BITS),
    .DictEntries (DICT_ENTRIES)
  ) u_step (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .code_i          (code_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .min_code_size_i (min_code_size_i),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .string_code_o   (string_code_o),
    .string_length_o (string_length_o),
    .first_byte_o    (first_byte_o),
    .last_byte_o     (last_byte_o),
    .entry_added_o   (entry_added_o),
    .added_index_o   (added_index_o),
    .next_width_o    (next_width_o)
  );

  glzw_dict_ram #(
    .DictEntries (DICT_ENTRIES)
  ) u_dict_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

endmodule

// File: bench/tb_gif_lzw_code_decoder.sv
// Self-checking testbench for the GIF LZW code decoder, with its own dictionary predictor.
module tb_gif_lzw_code_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import glzw_pkg::*;

  localparam int unsigned DICT_SIZE    = DICT_ENTRIES_DEF;
  localparam int unsigned WIDTH_CAP    = MAX_CODE_BITS_DEF;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned RANDOM_ITEMS = 830;
  localparam int unsigned FILL_TOP     = 512;

  typedef struct packed {
    status_e              status;
    logic [CODE_W-1:0]    string_code;
    logic [LEN_W-1:0]     string_length;
    logic [BYTE_W-1:0]    first_byte;
    logic [BYTE_W-1:0]    last_byte;
    logic                 entry_added;
    logic [CODE_W-1:0]    added_index;
    logic [WIDTH_W-1:0]   next_width;
  } result_t;

  typedef struct {
    bit      on;
    result_t r;
  } pin_t;

  typedef enum logic {ROW_CODE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [CODE_W-1:0] value;
    bit                on;
    result_t           r;
  } row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_RUNS} stall_mode_e;

  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [CODE_W-1:0]    code_i          = '0;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [SIZE_W-1:0]    min_code_size_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [2:0]           status_o;
  logic [CODE_W-1:0]    string_code_o;
  logic [LEN_W-1:0]     string_length_o;
  logic [BYTE_W-1:0]    first_byte_o;
  logic [BYTE_W-1:0]    last_byte_o;
  logic                 entry_added_o;
  logic [CODE_W-1:0]    added_index_o;
  logic [WIDTH_W-1:0]   next_width_o;

  gif_lzw_code_decoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .code_i          (code_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .min_code_size_i (min_code_size_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .string_code_o   (string_code_o),
    .string_length_o (string_length_o),
    .first_byte_o    (first_byte_o),
    .last_byte_o     (last_byte_o),
    .entry_added_o   (entry_added_o),
    .added_index_o   (added_index_o),
    .next_width_o    (next_width_o)
  );

  // Predictor state: a private copy of the decoder's dictionary and registers.
  logic [BYTE_W-1:0]  dict_suffix [DICT_SIZE];
  logic [LEN_W-1:0]   dict_len    [DICT_SIZE];
  logic [BYTE_W-1:0]  dict_head   [DICT_SIZE];
  logic [SIZE_W-1:0]  size_reg;
  int unsigned        free_idx;
  int unsigned        cur_width;
  logic [CODE_W-1:0]  prev_code;
  phase_e             dec_phase;

  result_t     expected_words [$];
  pin_t        pinned_words [$];
  int unsigned mismatches  = 0;
  int unsigned words_seen  = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_size();
    if (size_reg < MIN_SIZE_LO) return 32'(MIN_SIZE_LO);
    if (size_reg > MIN_SIZE_HI) return 32'(MIN_SIZE_HI);
    return 32'(size_reg);
  endfunction

  function automatic int unsigned clear_value();
    return 1 << eff_size();
  endfunction

  function automatic void restart_dict();
    cur_width = eff_size() + 1;
    free_idx  = clear_value() + 2;
  endfunction

  function automatic void load_min_size(input logic [SIZE_W-1:0] v);
    size_reg  = v;
    restart_dict();
    prev_code = '0;
    dec_phase = PH_WAIT_CLEAR;
  endfunction

  // Codes below the clear code are implicit one-byte strings.
  function automatic logic [LEN_W-1:0] str_len(input logic [CODE_W-1:0] c);
    if (c < clear_value()) return LEN_W'(1);
    return dict_len[c];
  endfunction

  function automatic logic [BYTE_W-1:0] str_first(input logic [CODE_W-1:0] c);
    if (c < clear_value()) return c[BYTE_W-1:0];
    return dict_head[c];
  endfunction

  function automatic logic [BYTE_W-1:0] str_last(input logic [CODE_W-1:0] c);
    if (c < clear_value()) return c[BYTE_W-1:0];
    return dict_suffix[c];
  endfunction

  function automatic bit add_entry(input logic [CODE_W-1:0] prev, input logic [BYTE_W-1:0] b,
                                   output int unsigned idx);
    int unsigned n;
    int unsigned len;
    n   = free_idx;
    idx = 0;
    if (n >= DICT_SIZE) return 1'b0;
    len = str_len(prev) + 1;
    if (len > LEN_MAX) len = 32'(LEN_MAX);
    dict_suffix[n] = b;
    dict_len[n]    = LEN_W'(len);
    dict_head[n]   = str_first(prev);
    // The width steps up once the last code of the current width is taken.
    if (n == (1 << cur_width) - 1 && cur_width < WIDTH_CAP) cur_width++;
    free_idx = n + 1;
    idx      = n;
    return 1'b1;
  endfunction

  function automatic result_t decode_code(input logic [CODE_W-1:0] c);
    result_t     r;
    int unsigned clr;
    int unsigned idx;
    logic [BYTE_W-1:0] b;
    r        = '0;
    r.status = ST_BAD;
    clr      = clear_value();
    if (dec_phase == PH_ENDED) begin
      r.status = ST_END;
    end else if (dec_phase == PH_WAIT_CLEAR && c != clr) begin
      r.status = ST_NO_CLEAR;
    end else if (c == clr) begin
      restart_dict();
      dec_phase = PH_FIRST;
      r.status  = ST_CLEAR;
    end else if (c == clr + 1) begin
      dec_phase = PH_ENDED;
      r.status  = ST_END;
    end else if (dec_phase == PH_FIRST) begin
      if (c < clr) begin
        r.status        = ST_EMIT;
        r.string_code   = c;
        r.string_length = LEN_W'(1);
        r.first_byte    = c[BYTE_W-1:0];
        r.last_byte     = c[BYTE_W-1:0];
        prev_code       = c;
        dec_phase       = PH_DECODE;
      end
    end else if (c < free_idx) begin
      r.status        = ST_EMIT;
      r.string_code   = c;
      r.string_length = str_len(c);
      r.first_byte    = str_first(c);
      r.last_byte     = str_last(c);
      r.entry_added   = add_entry(prev_code, r.first_byte, idx);
      r.added_index   = CODE_W'(idx);
      prev_code       = c;
    end else if (c == free_idx && free_idx < DICT_SIZE) begin
      // The code being defined right now: previous string plus its own first byte.
      b               = str_first(prev_code);
      r.entry_added   = add_entry(prev_code, b, idx);
      r.added_index   = CODE_W'(idx);
      r.status        = ST_EMIT;
      r.string_code   = c;
      r.string_length = str_len(c);
      r.first_byte    = b;
      r.last_byte     = b;
      prev_code       = c;
    end
    r.next_width = WIDTH_W'(cur_width);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_word(input result_t got, input result_t want);
    if (got.status !== want.status)
      report_mismatch($sformatf("word %0d status %0d, expected %0d",
                                words_seen, got.status, want.status));
    if (got.string_code !== want.string_code)
      report_mismatch($sformatf("word %0d string_code %0d, expected %0d",
                                words_seen, got.string_code, want.string_code));
    if (got.string_length !== want.string_length)
      report_mismatch($sformatf("word %0d string_length %0d, expected %0d",
                                words_seen, got.string_length, want.string_length));
    if (got.first_byte !== want.first_byte)
      report_mismatch($sformatf("word %0d first_byte %0d, expected %0d",
                                words_seen, got.first_byte, want.first_byte));
    if (got.last_byte !== want.last_byte)
      report_mismatch($sformatf("word %0d last_byte %0d, expected %0d",
                                words_seen, got.last_byte, want.last_byte));
    if (got.entry_added !== want.entry_added)
      report_mismatch($sformatf("word %0d entry_added %0d, expected %0d",
                                words_seen, got.entry_added, want.entry_added));
    if (got.added_index !== want.added_index)
      report_mismatch($sformatf("word %0d added_index %0d, expected %0d",
                                words_seen, got.added_index, want.added_index));
    if (got.next_width !== want.next_width)
      report_mismatch($sformatf("word %0d next_width %0d, expected %0d",
                                words_seen, got.next_width, want.next_width));
  endtask

  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t want;
    pin_t    pin;
    bit      moved;
    if (!rst_ni) begin
      load_min_size(RESET_MIN_SIZE);
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved             = 1'b1;
        got.status        = status_e'(status_o);
        got.string_code   = string_code_o;
        got.string_length = string_length_o;
        got.first_byte    = first_byte_o;
        got.last_byte     = last_byte_o;
        got.entry_added   = entry_added_o;
        got.added_index   = added_index_o;
        got.next_width    = next_width_o;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
        end else begin
          want = expected_words.pop_front();
          check_word(got, want);
        end
        words_seen++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        load_min_size(min_code_size_i);
      end
      if (in_valid_i && !in_stall_o) begin
        moved          = 1'b1;
        pin            = pinned_words.pop_front();
        want           = decode_code(code_i);
        expected_words = {expected_words, (pin.on ? pin.r : want)};
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("tb_gif_lzw_code_decoder failed");
    $finish;
  end

  initial begin : receiver_pattern
    stall_mode_e mode;
    int unsigned span;
    int unsigned period;
    int unsigned run_left;
    int unsigned cyc;
    bit          hold;
    forever begin
      mode     = stall_mode_e'($urandom_range(0, 3));
      span     = $urandom_range(20, 200);
      period   = $urandom_range(2, 5);
      run_left = 0;
      hold     = 1'b0;
      for (cyc = 0; cyc < span; cyc++) begin
        @(negedge clk_i);
        case (mode)
          STALL_NONE:     out_stall_i <= 1'b0;
          STALL_RANDOM:   out_stall_i <= ($urandom_range(0, 9) < 4);
          STALL_PERIODIC: out_stall_i <= (cyc % period == 0);
          default: begin
            if (run_left == 0) begin
              hold     = !hold;
              run_left = hold ? $urandom_range(5, 50) : $urandom_range(1, 8);
            end
            run_left--;
            out_stall_i <= hold;
          end
        endcase
      end
    end
  end

  // Sends one code word; the sender works in bursts with random gaps between them.
  task automatic send_code(input logic [CODE_W-1:0] c, input bit on = 1'b0,
                           input result_t r = '0);
    int unsigned gap;
    pin_t        pin;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(8, 40);
      else gap = $urandom_range(1, 4);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    pin.on = on;
    pin.r  = r;
    pinned_words = {pinned_words, pin};
    in_valid_i <= 1'b1;
    code_i     <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    items_sent++;
    @(negedge clk_i);
  endtask

  // The register is written only once every code in flight has come back.
  task automatic write_min_size(input logic [SIZE_W-1:0] v);
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    cfg_valid_i     <= 1'b1;
    min_code_size_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CODE_W-1:0] known_code();
    int unsigned clr;
    clr = clear_value();
    if (free_idx > clr + 2 && $urandom_range(0, 2) != 0)
      return CODE_W'($urandom_range(clr + 2, free_idx - 1));
    return CODE_W'($urandom_range(0, clr - 1));
  endfunction

  // Mostly well-formed codes for the current decoder state, with some bad ones mixed in.
  function automatic logic [CODE_W-1:0] next_code();
    int unsigned clr;
    int unsigned roll;
    clr  = clear_value();
    roll = $urandom_range(0, 99);
    if (dec_phase == PH_FIRST) begin
      if (roll < 90) return CODE_W'($urandom_range(0, clr - 1));
      if (roll < 95) return CODE_W'($urandom_range(clr + 2, DICT_SIZE - 1));
      return CODE_W'(clr);
    end
    if (dec_phase != PH_DECODE) return CODE_W'($urandom_range(0, DICT_SIZE - 1));
    if (roll < 65) return known_code();
    if (roll < 88 && free_idx < DICT_SIZE) return CODE_W'(free_idx);
    if (roll < 96 && free_idx < DICT_SIZE - 1)
      return CODE_W'($urandom_range(free_idx + 1, DICT_SIZE - 1));
    if (roll < 99) return CODE_W'(clr);
    return CODE_W'(clr + 1);
  endfunction

  function automatic result_t quiet_result(input status_e s, input logic [WIDTH_W-1:0] w);
    result_t r;
    r            = '0;
    r.status     = s;
    r.next_width = w;
    return r;
  endfunction

  function automatic result_t root_result(input logic [CODE_W-1:0] c,
                                          input logic [WIDTH_W-1:0] w);
    result_t r;
    r               = quiet_result(ST_EMIT, w);
    r.string_code   = c;
    r.string_length = LEN_W'(1);
    r.first_byte    = c[BYTE_W-1:0];
    r.last_byte     = c[BYTE_W-1:0];
    return r;
  endfunction

  function automatic row_t pinned_row(input logic [CODE_W-1:0] c, input result_t r);
    row_t row;
    row.kind  = ROW_CODE;
    row.value = c;
    row.on    = 1'b1;
    row.r     = r;
    return row;
  endfunction

  function automatic row_t free_row(input logic [CODE_W-1:0] c);
    row_t row;
    row       = pinned_row(c, '0);
    row.on    = 1'b0;
    return row;
  endfunction

  function automatic row_t cfg_row(input logic [SIZE_W-1:0] v);
    row_t row;
    row       = free_row(CODE_W'(v));
    row.kind  = ROW_CFG;
    return row;
  endfunction

  initial begin : stimulus
    row_t        rows [$];
    int unsigned start;
    int unsigned span;
    logic [SIZE_W-1:0] sz;

    // After reset the minimum size is 8: clear 256, end of information 257, width 9.
    rows = {rows, pinned_row(12'd0,    quiet_result(ST_NO_CLEAR, 4'd9))};
    rows = {rows, pinned_row(12'd4095, quiet_result(ST_NO_CLEAR, 4'd9))};
    rows = {rows, pinned_row(12'd257,  quiet_result(ST_NO_CLEAR, 4'd9))};
    rows = {rows, pinned_row(12'd256,  quiet_result(ST_CLEAR, 4'd9))};
    rows = {rows, pinned_row(12'd300,  quiet_result(ST_BAD, 4'd9))};
    rows = {rows, pinned_row(12'd256,  quiet_result(ST_CLEAR, 4'd9))};
    rows = {rows, pinned_row(12'd65,   root_result(12'd65, 4'd9))};
    rows = {rows, free_row(12'd66)};
    rows = {rows, free_row(12'd258)};
    rows = {rows, free_row(12'd260)};
    rows = {rows, pinned_row(12'd262,  quiet_result(ST_BAD, 4'd9))};
    rows = {rows, free_row(12'd255)};
    rows = {rows, free_row(12'd0)};
    rows = {rows, pinned_row(12'd257,  quiet_result(ST_END, 4'd9))};
    rows = {rows, pinned_row(12'd256,  quiet_result(ST_END, 4'd9))};
    // Smallest size: clear 4, end of information 5, width 3 growing to 4 at entry 7.
    rows = {rows, cfg_row(4'd2)};
    rows = {rows, pinned_row(12'd3,    quiet_result(ST_NO_CLEAR, 4'd3))};
    rows = {rows, pinned_row(12'd4,    quiet_result(ST_CLEAR, 4'd3))};
    rows = {rows, pinned_row(12'd5,    quiet_result(ST_END, 4'd3))};
    rows = {rows, cfg_row(4'd2)};
    rows = {rows, pinned_row(12'd4,    quiet_result(ST_CLEAR, 4'd3))};
    rows = {rows, free_row(12'd1)};
    rows = {rows, free_row(12'd6)};
    rows = {rows, free_row(12'd7)};
    rows = {rows, free_row(12'd3)};
    rows = {rows, free_row(12'd9)};
    // Out-of-range sizes act as the nearest legal size.
    rows = {rows, cfg_row(4'd15)};
    rows = {rows, pinned_row(12'd256,  quiet_result(ST_CLEAR, 4'd9))};
    rows = {rows, pinned_row(12'd0,    root_result(12'd0, 4'd9))};
    rows = {rows, cfg_row(4'd0)};
    rows = {rows, pinned_row(12'd4,    quiet_result(ST_CLEAR, 4'd3))};
    rows = {rows, pinned_row(12'd3,    root_result(12'd3, 4'd3))};
    rows = {rows, pinned_row(12'd15,   quiet_result(ST_BAD, 4'd3))};
    rows = {rows, pinned_row(12'd5,    quiet_result(ST_END, 4'd3))};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_min_size(rows[i].value[SIZE_W-1:0]);
      else send_code(rows[i].value, rows[i].on, rows[i].r);
    end

    // One long pass that walks the width up from three bits to ten.
    write_min_size(4'd2);
    send_code(CODE_W'(clear_value()));
    send_code(CODE_W'($urandom_range(0, 3)));
    while (free_idx < FILL_TOP)
      send_code(($urandom_range(0, 4) < 3) ? CODE_W'(free_idx) : known_code());
    send_code(CODE_W'(DICT_SIZE - 1));
    repeat (30) send_code(known_code());
    send_code(CODE_W'(clear_value() + 1));

    // Random streams: mostly clear followed by valid codes, with noise and early ends.
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 3) == 0) sz = SIZE_W'($urandom_range(0, 15));
        else if ($urandom_range(0, 2) == 0) sz = ($urandom_range(0, 1) != 0) ? MIN_SIZE_LO
                                                                            : MIN_SIZE_HI;
        else sz = SIZE_W'($urandom_range(MIN_SIZE_LO, MIN_SIZE_HI));
        write_min_size(sz);
      end
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4)) send_code(CODE_W'($urandom_range(0, DICT_SIZE - 1)));
      send_code(CODE_W'(clear_value()));
      span = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(3, 40);
      repeat (span) send_code(next_code());
      if ($urandom_range(0, 2) == 0) begin
        send_code(CODE_W'(clear_value() + 1));
        repeat ($urandom_range(0, 3)) send_code(CODE_W'($urandom_range(0, DICT_SIZE - 1)));
      end
    end

    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb_gif_lzw_code_decoder passed");
    end else begin
      $display("tb_gif_lzw_code_decoder failed");
    end
    $finish;
  end

endmodule
